// ===== rtl/core/yolo_row_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// YOLO row decoder assertion macros
// Shared concurrent assertion helpers for the row decoder RTL.
// ----------------------------------------------------------------------------
`ifndef YOLO_ROW_DECODER_DEFINES_SVH
`define YOLO_ROW_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define YRD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define YRD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define YRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define YRD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/core/yrd_pkg.sv =====
// ----------------------------------------------------------------------------
// YOLO row decoder package
// Widths, register indexes, shared structures and the pixel scaling function.
// ----------------------------------------------------------------------------
package yrd_pkg;

    localparam int ELEM_W     = 16;
    localparam int PIX_W      = 13;
    localparam int POS_W      = 14;
    localparam int CLASS_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int FRAC_BITS  = 16;
    localparam int BOX_FIELDS = 5;
    localparam int PROD_W     = ELEM_W + PIX_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Largest row position: four box elements after the first plus 255 classes.
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(BOX_FIELDS - 1 + 255);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_W     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_H     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES = CFG_IDX_W'(3);

    localparam logic [ELEM_W-1:0]  RST_THRESHOLD   = ELEM_W'(32768);
    localparam logic [PIX_W-1:0]   RST_IMAGE_SIZE  = PIX_W'(416);
    localparam logic [CLASS_W-1:0] RST_NUM_CLASSES = CLASS_W'(80);

    typedef struct packed {
        logic [ELEM_W-1:0]  threshold;
        logic [PIX_W-1:0]   image_w;
        logic [PIX_W-1:0]   image_h;
        logic [CLASS_W-1:0] num_classes;
    } t_cfg;

    typedef struct packed {
        logic [ELEM_W-1:0]  cx;
        logic [ELEM_W-1:0]  cy;
        logic [ELEM_W-1:0]  w;
        logic [ELEM_W-1:0]  h;
        logic [ELEM_W-1:0]  score;
        logic [CLASS_W-1:0] cls;
    } t_cand;

    // Scales a fraction by an image size, truncating and saturating to the pixel range.
    function automatic logic [PIX_W-1:0] to_pixels(input logic [ELEM_W-1:0] raw,
                                                   input logic [PIX_W-1:0] size);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] shifted;
        prod    = PROD_W'(raw) * PROD_W'(size);
        shifted = prod >> FRAC_BITS;
        if (shifted[PROD_W-1:PIX_W] != '0) begin
            return '1;
        end else begin
            return shifted[PIX_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/yolo_row_decoder.sv =====
// Once the last word of a row is taken, its box passes the candidate and pixel registers to the output register.
// Throughput: one element per cycle while o_in_ready is high.
// Detections wait in a candidate, a pixel and an output register, so input
// flow stalls only when all three are full and the output is held.
// Reset: threshold 32768, image size 416 x 416, 80 classes, row position 0.
// ----------------------------------------------------------------------------
// YOLO row decoder
// Decodes a streamed detector row into at most one thresholded pixel box.
// ----------------------------------------------------------------------------
module yolo_row_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [yrd_pkg::ELEM_W-1:0]         i_element_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [yrd_pkg::POS_W-1:0]   o_box_left,
    output logic signed [yrd_pkg::POS_W-1:0]   o_box_top,
    output logic [yrd_pkg::PIX_W-1:0]          o_box_width,
    output logic [yrd_pkg::PIX_W-1:0]          o_box_height,
    output logic [yrd_pkg::ELEM_W-1:0]         o_box_score,
    output logic [yrd_pkg::CLASS_W-1:0]        o_box_class,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [yrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [yrd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    yrd_pkg::t_cfg  r_cfg;
    yrd_pkg::t_cand cand;
    logic           cand_valid;
    logic           cand_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= yrd_pkg::RST_THRESHOLD;
            r_cfg.image_w     <= yrd_pkg::RST_IMAGE_SIZE;
            r_cfg.image_h     <= yrd_pkg::RST_IMAGE_SIZE;
            r_cfg.num_classes <= yrd_pkg::RST_NUM_CLASSES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                yrd_pkg::CFG_THRESHOLD:   r_cfg.threshold   <= i_cfg_data;
                yrd_pkg::CFG_IMAGE_W:     r_cfg.image_w     <= i_cfg_data[yrd_pkg::PIX_W-1:0];
                yrd_pkg::CFG_IMAGE_H:     r_cfg.image_h     <= i_cfg_data[yrd_pkg::PIX_W-1:0];
                yrd_pkg::CFG_NUM_CLASSES: r_cfg.num_classes <= i_cfg_data[yrd_pkg::CLASS_W-1:0];
                default: ;
            endcase
        end
    end

    yrd_row_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_value      (i_element_value),
        .i_cfg        (r_cfg),
        .o_cand_valid (cand_valid),
        .i_cand_ready (cand_ready),
        .o_cand       (cand)
    );

    yrd_box_scaler u_scaler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand_valid (cand_valid),
        .o_cand_ready (cand_ready),
        .i_cand       (cand),
        .i_cfg        (r_cfg),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height),
        .o_box_score  (o_box_score),
        .o_box_class  (o_box_class)
    );

endmodule

// ===== rtl/core/yrd_row_tracker.sv =====
// ----------------------------------------------------------------------------
// YOLO row tracker
// Follows the position in a row, keeps the box elements and the first best
// class score, and hands a passing detection on as a candidate.
// ----------------------------------------------------------------------------
`include "yolo_row_decoder_defines.svh"

module yrd_row_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [yrd_pkg::ELEM_W-1:0]     i_value,
    input  yrd_pkg::t_cfg                  i_cfg,
    output logic                           o_cand_valid,
    input  logic                           i_cand_ready,
    output yrd_pkg::t_cand                 o_cand
);

    logic [yrd_pkg::COUNT_W-1:0] r_count;
    logic [yrd_pkg::ELEM_W-1:0]  r_cx, r_cy, r_w, r_h, r_obj;
    logic [yrd_pkg::ELEM_W-1:0]  r_best_score;
    logic [yrd_pkg::CLASS_W-1:0] r_best_index;
    logic                        r_cand_valid;
    yrd_pkg::t_cand              r_cand;

    logic                        accept;
    logic                        cand_take;
    logic [yrd_pkg::CLASS_W-1:0] nc;
    logic [yrd_pkg::COUNT_W-1:0] last;
    logic [yrd_pkg::COUNT_W-1:0] k;
    logic                        is_box;
    logic                        row_end;
    logic                        take_best;
    logic [yrd_pkg::ELEM_W-1:0]  n_best_score;
    logic [yrd_pkg::CLASS_W-1:0] n_best_index;
    logic                        pass;
    logic                        n_cand_valid;

    assign cand_take = r_cand_valid && i_cand_ready;
    assign o_ready   = !r_cand_valid || i_cand_ready;
    assign accept    = i_valid && o_ready;

    // A class count of zero behaves as one class.
    assign nc      = (i_cfg.num_classes == '0) ? yrd_pkg::CLASS_W'(1) : i_cfg.num_classes;
    assign last    = yrd_pkg::COUNT_W'(yrd_pkg::BOX_FIELDS - 1) + yrd_pkg::COUNT_W'(nc);
    assign is_box  = r_count < yrd_pkg::COUNT_W'(yrd_pkg::BOX_FIELDS);
    assign k       = r_count - yrd_pkg::COUNT_W'(yrd_pkg::BOX_FIELDS);
    assign row_end = !is_box && (r_count >= last);

    // Equal later scores leave the earlier best in place.
    assign take_best    = (k == '0) || (i_value > r_best_score);
    assign n_best_score = take_best ? i_value : r_best_score;
    assign n_best_index = take_best ? k[yrd_pkg::CLASS_W-1:0] : r_best_index;
    assign pass         = (r_obj > i_cfg.threshold) && (n_best_score > i_cfg.threshold);

    // A new candidate can only be loaded when the old one leaves or none is held.
    assign n_cand_valid = (r_cand_valid && !cand_take) || (accept && row_end && pass);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_cand_valid <= 1'b0;
        end else begin
            r_cand_valid <= n_cand_valid;
            if (accept) begin
                if (is_box) begin
                    unique case (r_count[2:0])
                        3'd0:    r_cx  <= i_value;
                        3'd1:    r_cy  <= i_value;
                        3'd2:    r_w   <= i_value;
                        3'd3:    r_h   <= i_value;
                        default: r_obj <= i_value;
                    endcase
                    r_count <= r_count + 1'b1;
                end else begin
                    r_best_score <= n_best_score;
                    r_best_index <= n_best_index;
                    if (row_end) begin
                        r_count <= '0;
                        if (pass) begin
                            r_cand.cx    <= r_cx;
                            r_cand.cy    <= r_cy;
                            r_cand.w     <= r_w;
                            r_cand.h     <= r_h;
                            r_cand.score <= n_best_score;
                            r_cand.cls   <= n_best_index;
                        end
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end
        end
    end

    assign o_cand_valid = r_cand_valid;
    assign o_cand       = r_cand;

    `YRD_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > yrd_pkg::COUNT_MAX,
                      "row position beyond the longest row")
    `YRD_ASSERT(a_cand_from_accept, i_clk, i_rst_n, $rose(r_cand_valid) |-> $past(accept),
                "candidate appeared without an accepted element")
    `YRD_ASSERT(a_row_restart, i_clk, i_rst_n, (accept && row_end) |=> (r_count == '0),
                "row position not cleared after the last element")

endmodule

// ===== rtl/core/yrd_box_scaler.sv =====
// ----------------------------------------------------------------------------
// YOLO box scaler
// Converts a candidate to pixel units in one stage and forms the left and
// top corner in the output register stage.
// ----------------------------------------------------------------------------
module yrd_box_scaler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cand_valid,
    output logic                               o_cand_ready,
    input  yrd_pkg::t_cand                     i_cand,
    input  yrd_pkg::t_cfg                      i_cfg,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [yrd_pkg::POS_W-1:0]   o_box_left,
    output logic signed [yrd_pkg::POS_W-1:0]   o_box_top,
    output logic [yrd_pkg::PIX_W-1:0]          o_box_width,
    output logic [yrd_pkg::PIX_W-1:0]          o_box_height,
    output logic [yrd_pkg::ELEM_W-1:0]         o_box_score,
    output logic [yrd_pkg::CLASS_W-1:0]        o_box_class
);

    typedef struct packed {
        logic [yrd_pkg::PIX_W-1:0]   cx;
        logic [yrd_pkg::PIX_W-1:0]   cy;
        logic [yrd_pkg::PIX_W-1:0]   w;
        logic [yrd_pkg::PIX_W-1:0]   h;
        logic [yrd_pkg::ELEM_W-1:0]  score;
        logic [yrd_pkg::CLASS_W-1:0] cls;
    } t_pix;

    logic  r_pix_valid;
    t_pix  r_pix;
    logic  r_out_valid;
    logic  out_free;
    logic  pix_free;
    logic signed [yrd_pkg::POS_W-1:0] n_left;
    logic signed [yrd_pkg::POS_W-1:0] n_top;

    assign out_free     = !r_out_valid || i_out_ready;
    assign pix_free     = !r_pix_valid || out_free;
    assign o_cand_ready = pix_free;

    // Halves are truncated before the subtraction.
    assign n_left = signed'({1'b0, r_pix.cx}) - signed'({2'b00, r_pix.w[yrd_pkg::PIX_W-1:1]});
    assign n_top  = signed'({1'b0, r_pix.cy}) - signed'({2'b00, r_pix.h[yrd_pkg::PIX_W-1:1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pix_free) begin
                r_pix_valid <= i_cand_valid;
            end
            if (out_free) begin
                r_out_valid <= r_pix_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_free && i_cand_valid) begin
            r_pix.cx    <= yrd_pkg::to_pixels(i_cand.cx, i_cfg.image_w);
            r_pix.cy    <= yrd_pkg::to_pixels(i_cand.cy, i_cfg.image_h);
            r_pix.w     <= yrd_pkg::to_pixels(i_cand.w, i_cfg.image_w);
            r_pix.h     <= yrd_pkg::to_pixels(i_cand.h, i_cfg.image_h);
            r_pix.score <= i_cand.score;
            r_pix.cls   <= i_cand.cls;
        end
        if (out_free && r_pix_valid) begin
            o_box_left   <= n_left;
            o_box_top    <= n_top;
            o_box_width  <= r_pix.w;
            o_box_height <= r_pix.h;
            o_box_score  <= r_pix.score;
            o_box_class  <= r_pix.cls;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Row decoder testbench
// Streams detector rows into the decoder under random idling on both sides.
// A predictor follows every accepted word, and a monitor checks each box
// against the oldest prediction. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import yrd_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_SHOWN    = 10;
    localparam int GAP_MAX      = 19;
    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    typedef struct packed {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] top;
        logic [PIX_W-1:0]        width;
        logic [PIX_W-1:0]        height;
        logic [ELEM_W-1:0]       score;
        logic [CLASS_W-1:0]      cls;
    } t_pixel_box;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic [ELEM_W-1:0]      element_value = '0;
    logic                   out_ready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   o_in_ready;
    logic                   o_out_valid;
    logic                   o_cfg_ready;
    logic signed [POS_W-1:0] o_box_left;
    logic signed [POS_W-1:0] o_box_top;
    logic [PIX_W-1:0]       o_box_width;
    logic [PIX_W-1:0]       o_box_height;
    logic [ELEM_W-1:0]      o_box_score;
    logic [CLASS_W-1:0]     o_box_class;

    // Register copies held by the predictor.
    logic [ELEM_W-1:0]  thr_cfg;
    logic [PIX_W-1:0]   img_w_cfg;
    logic [PIX_W-1:0]   img_h_cfg;
    logic [CLASS_W-1:0] classes_cfg;

    // Row state held by the predictor.
    logic [COUNT_W-1:0] row_pos;
    logic [ELEM_W-1:0]  cx_raw, cy_raw, w_raw, h_raw, obj_raw, top_score;
    logic [CLASS_W-1:0] top_class;

    logic [ELEM_W-1:0]  element_q [$];
    t_pixel_box         expected_boxes [$];

    bit idle_on = 1'b1;
    bit calm = 1'b0;
    bit send_busy = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    int stall_cycles = 0;
    int elements_taken = 0;
    int rows_done = 0;
    int boxes_matched = 0;
    int mismatches = 0;
    int unexpected = 0;
    int shown = 0;
    int reg_writes = 0;
    int failures;

    yolo_row_decoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_element_value (element_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_box_left      (o_box_left),
        .o_box_top       (o_box_top),
        .o_box_width     (o_box_width),
        .o_box_height    (o_box_height),
        .o_box_score     (o_box_score),
        .o_box_class     (o_box_class),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [PIX_W-1:0] frac_to_pixels(input logic [ELEM_W-1:0] frac,
                                                        input logic [PIX_W-1:0] size);
        logic [31:0] scaled;
        scaled = (32'(frac) * 32'(size)) >> FRAC_BITS;
        return (scaled > 32'(PIX_MAX)) ? PIX_MAX : scaled[PIX_W-1:0];
    endfunction

    function automatic logic [ELEM_W-1:0] rand_above(input logic [ELEM_W-1:0] t);
        return (t == '1) ? t : ELEM_W'($urandom_range(32'hFFFF, 32'(t) + 1));
    endfunction

    function automatic logic [ELEM_W-1:0] rand_upto(input logic [ELEM_W-1:0] t);
        return ELEM_W'($urandom_range(32'(t), 0));
    endfunction

    // Appends one word to the tail of the send queue.
    task automatic add_word(input logic [ELEM_W-1:0] w);
        element_q.insert(element_q.size(), w);
    endtask

    // Follows one accepted word and queues the box it completes, if any.
    task automatic decode_element(input logic [ELEM_W-1:0] v);
        logic [COUNT_W-1:0] row_end;
        logic [COUNT_W-1:0] k;
        logic [PIX_W-1:0]   px_x, px_y, px_w, px_h;
        t_pixel_box         box;
        row_end = COUNT_W'(BOX_FIELDS - 1)
                  + ((classes_cfg == '0) ? COUNT_W'(1) : COUNT_W'(classes_cfg));
        if (row_pos < COUNT_W'(BOX_FIELDS)) begin
            case (row_pos)
                COUNT_W'(0): cx_raw = v;
                COUNT_W'(1): cy_raw = v;
                COUNT_W'(2): w_raw = v;
                COUNT_W'(3): h_raw = v;
                default:     obj_raw = v;
            endcase
            row_pos = row_pos + 1'b1;
        end else begin
            k = row_pos - COUNT_W'(BOX_FIELDS);
            if (k == '0 || v > top_score) begin
                top_score = v;
                top_class = k[CLASS_W-1:0];
            end
            // A position at or past the row end also closes the row, which
            // covers a class count lowered part way through.
            if (row_pos < row_end) begin
                row_pos = row_pos + 1'b1;
            end else begin
                row_pos = '0;
                rows_done++;
                if (obj_raw > thr_cfg && top_score > thr_cfg) begin
                    px_x = frac_to_pixels(cx_raw, img_w_cfg);
                    px_y = frac_to_pixels(cy_raw, img_h_cfg);
                    px_w = frac_to_pixels(w_raw, img_w_cfg);
                    px_h = frac_to_pixels(h_raw, img_h_cfg);
                    box.left   = $signed({1'b0, px_x}) - $signed({2'b00, px_w[PIX_W-1:1]});
                    box.top    = $signed({1'b0, px_y}) - $signed({2'b00, px_h[PIX_W-1:1]});
                    box.width  = px_w;
                    box.height = px_h;
                    box.score  = top_score;
                    box.cls    = top_class;
                    expected_boxes.insert(expected_boxes.size(), box);
                end
            end
        end
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_THRESHOLD:   thr_cfg = data;
            CFG_IMAGE_W:     img_w_cfg = data[PIX_W-1:0];
            CFG_IMAGE_H:     img_h_cfg = data[PIX_W-1:0];
            CFG_NUM_CLASSES: classes_cfg = data[CLASS_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Returns once every queued word is taken, every box has come out and the
    // pipeline has had time to retire a row that produced nothing.
    task automatic wait_idle();
        while (element_q.size() != 0 || send_busy || expected_boxes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Queues a row head and n_scores class scores. A row meant to miss fails
    // either on objectness or on every score.
    task automatic queue_row(input int n_scores, input bit want_box);
        logic [ELEM_W-1:0] pool [2];
        logic [ELEM_W-1:0] word;
        bit tie_mode, fail_obj;
        int hot, i, pick;
        tie_mode = ($urandom_range(0, 3) == 0);
        fail_obj = ($urandom_range(0, 1) == 1);
        hot = $urandom_range(0, n_scores - 1);
        pool[0] = rand_above(thr_cfg);
        pool[1] = ELEM_W'($urandom);
        for (i = 0; i < 4; i++) begin
            pick = $urandom_range(0, 7);
            word = (pick == 0) ? '0 : (pick == 1) ? '1 : ELEM_W'($urandom);
            add_word(word);
        end
        add_word((want_box || !fail_obj) ? rand_above(thr_cfg) : rand_upto(thr_cfg));
        for (i = 0; i < n_scores; i++) begin
            if (!want_box && !fail_obj) begin
                word = rand_upto(thr_cfg);
            end else begin
                word = tie_mode ? pool[$urandom_range(0, 1)] : ELEM_W'($urandom);
                if (want_box && i == hot && word <= thr_cfg) begin
                    word = tie_mode ? pool[0] : rand_above(thr_cfg);
                end
            end
            add_word(word);
        end
    endtask

    // Mostly whole rows, with short bursts of stray words that knock the
    // row position out of step.
    task automatic run_random(input int items, input int noise_pct);
        int classes, queued, n, i;
        classes = (classes_cfg == '0) ? 1 : int'(classes_cfg);
        queued = 0;
        while (queued < items) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                n = $urandom_range(1, 9);
                for (i = 0; i < n; i++) add_word(ELEM_W'($urandom));
            end else begin
                n = BOX_FIELDS + classes;
                queue_row(classes, $urandom_range(0, 3) != 0);
            end
            queued += n;
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) begin
            calm <= ~calm;
        end
    end

    always @(posedge i_clk) begin : element_driver
        logic              next_valid;
        logic [ELEM_W-1:0] next_word;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_busy = 1'b0;
        end else if (!(in_valid && !o_in_ready)) begin
            if (in_valid) begin
                decode_element(element_value);
                elements_taken++;
            end
            next_valid = 1'b0;
            next_word  = element_value;
            if (send_gap > 0) begin
                send_gap--;
            end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, GAP_MAX) - 1;
            end else if (element_q.size() > 0) begin
                next_valid = 1'b1;
                next_word  = element_q.pop_front();
            end
            send_busy = next_valid;
            in_valid      <= next_valid;
            element_value <= next_word;
        end
    end

    always @(posedge i_clk) begin : box_monitor
        t_pixel_box want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_boxes.size() == 0) begin
                    unexpected++;
                    if (shown < MAX_SHOWN) begin
                        shown++;
                        $display("[%0t] unexpected box: l %0d t %0d w %0d h %0d s %0d c %0d",
                                 $realtime, o_box_left, o_box_top, o_box_width, o_box_height,
                                 o_box_score, o_box_class);
                    end
                end else begin
                    want = expected_boxes.pop_front();
                    if (o_box_left !== want.left || o_box_top !== want.top
                        || o_box_width !== want.width || o_box_height !== want.height
                        || o_box_score !== want.score || o_box_class !== want.cls) begin
                        mismatches++;
                        if (shown < MAX_SHOWN) begin
                            shown++;
                            $display("[%0t] mismatch: want l %0d t %0d w %0d h %0d s %0d c %0d",
                                     $realtime, want.left, want.top, want.width, want.height,
                                     want.score, want.cls);
                            $display("           got  l %0d t %0d w %0d h %0d s %0d c %0d",
                                     o_box_left, o_box_top, o_box_width, o_box_height,
                                     o_box_score, o_box_class);
                        end
                    end else begin
                        boxes_matched++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, GAP_MAX) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] no word moved for %0d cycles, %0d boxes still awaited",
                         $realtime, stall_cycles, expected_boxes.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        thr_cfg     = RST_THRESHOLD;
        img_w_cfg   = RST_IMAGE_SIZE;
        img_h_cfg   = RST_IMAGE_SIZE;
        classes_cfg = RST_NUM_CLASSES;
        row_pos     = '0;
        cx_raw      = '0;
        cy_raw      = '0;
        w_raw       = '0;
        h_raw       = '0;
        obj_raw     = '0;
        top_score   = '0;
        top_class   = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows with two classes: a tie on full-scale scores with a
        // box running off the left edge, then a best score equal to the
        // threshold, which must not pass.
        set_reg(CFG_NUM_CLASSES, CFG_DATA_W'(2));
        add_word(16'h0000); add_word(16'hFFFF);
        add_word(16'hFFFF); add_word(16'hFFFF);
        add_word(16'hFFFF); add_word(16'hFFFF);
        add_word(16'hFFFF);
        add_word(16'h8000); add_word(16'h4000);
        add_word(16'h1234); add_word(16'h0001);
        add_word(16'hFFFF); add_word(16'h8000);
        add_word(16'h8000);
        wait_idle();

        // A class count of zero acts as one, and a zero width scales to nothing.
        set_reg(CFG_NUM_CLASSES, CFG_DATA_W'(0));
        set_reg(CFG_IMAGE_W, CFG_DATA_W'(0));
        set_reg(CFG_IMAGE_H, CFG_DATA_W'(8191));
        add_word(16'hFFFF); add_word(16'hFFFF);
        add_word(16'h8000); add_word(16'h0000);
        add_word(16'hFFFF); add_word(16'hFFFF);
        wait_idle();

        // Class count lowered part way through a row: the next score ends it.
        set_reg(CFG_NUM_CLASSES, CFG_DATA_W'(3));
        set_reg(CFG_IMAGE_W, CFG_DATA_W'(416));
        add_word(16'h4000); add_word(16'hC000);
        add_word(16'h2000); add_word(16'h6000);
        add_word(16'hFFFF); add_word(16'h7FFF);
        add_word(16'h9000);
        wait_idle();
        set_reg(CFG_NUM_CLASSES, CFG_DATA_W'(1));
        add_word(16'h9000);
        wait_idle();

        set_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(20000, 50000)));
        set_reg(CFG_IMAGE_W, CFG_DATA_W'($urandom_range(1, 8191)));
        set_reg(CFG_IMAGE_H, CFG_DATA_W'($urandom_range(1, 8191)));
        set_reg(CFG_NUM_CLASSES, CFG_DATA_W'($urandom_range(1, 6)));
        run_random(350, 10);

        // Widest frame and lowest threshold; upper data bits are dropped and
        // an index outside the register map is ignored.
        set_reg(CFG_THRESHOLD, CFG_DATA_W'(0));
        set_reg(CFG_IMAGE_W, 16'hFFFF);
        set_reg(CFG_IMAGE_H, CFG_DATA_W'(8191));
        set_reg(CFG_NUM_CLASSES, 16'hFF01);
        set_reg(CFG_IDX_W'(8'hFF), 16'h0000);
        run_random(250, 5);

        // Nothing can beat the top threshold, so no box may appear.
        set_reg(CFG_THRESHOLD, CFG_DATA_W'(65535));
        set_reg(CFG_IMAGE_W, CFG_DATA_W'(1));
        set_reg(CFG_IMAGE_H, CFG_DATA_W'(1));
        set_reg(CFG_NUM_CLASSES, CFG_DATA_W'(0));
        run_random(150, 10);

        // Longest rows, then one cut short by a lower class count.
        set_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 40000)));
        set_reg(CFG_IMAGE_W, CFG_DATA_W'(0));
        set_reg(CFG_IMAGE_H, CFG_DATA_W'($urandom_range(1, 8191)));
        set_reg(CFG_NUM_CLASSES, CFG_DATA_W'(255));
        queue_row(255, 1'b1);
        queue_row(255, 1'b1);
        queue_row(40, 1'b1);
        wait_idle();
        set_reg(CFG_NUM_CLASSES, CFG_DATA_W'(10));
        add_word(ELEM_W'($urandom));
        wait_idle();

        set_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 65535)));
        set_reg(CFG_IMAGE_W, CFG_DATA_W'($urandom_range(1, 8191)));
        set_reg(CFG_IMAGE_H, CFG_DATA_W'($urandom_range(1, 8191)));
        set_reg(CFG_NUM_CLASSES, CFG_DATA_W'($urandom_range(1, 8)));
        run_random(400, 15);

        // Closing stretch at full rate on both sides.
        idle_on = 1'b0;
        set_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(10000, 40000)));
        set_reg(CFG_IMAGE_W, CFG_DATA_W'($urandom_range(1, 8191)));
        set_reg(CFG_IMAGE_H, CFG_DATA_W'($urandom_range(1, 8191)));
        set_reg(CFG_NUM_CLASSES, CFG_DATA_W'($urandom_range(1, 4)));
        run_random(250, 5);

        failures = mismatches + unexpected + expected_boxes.size();
        $display("Streamed %0d words in %0d rows and checked %0d boxes over %0d register writes,",
                 elements_taken, rows_done, boxes_matched, reg_writes);
        $display("with thresholds from 0 to full scale, frame sizes 0 to 8191 and 0 to 255 classes.");
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
